// File: src/dtb_pkg.sv
// ----------------------------------------------------------------------------
// dtb_pkg
// Shared constants, operation codes and the command type that travels from
// the front end through the command queue to the execution unit.
// ----------------------------------------------------------------------------
package dtb_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int KIND_W    = 3;
  localparam int INSLOT_W  = 5;
  localparam int FOUND_W   = 5;
  localparam int DUR_W     = 32;
  localparam int NOW_W     = 48;
  localparam int DL_W      = 50;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [NOW_W-1:0]   NOW_MAX   = {NOW_W{1'b1}};
  localparam logic [FOUND_W-1:0] SLOT_NONE = FOUND_W'(NUM_SLOTS);

  // Operation codes; the front end folds unused kinds and no-effect
  // commands into KIND_NOP.
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_ONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OLDEST  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NOP     = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic                    slot_ok;
    logic [SLOT_W-1:0]       slot;
    logic signed [DUR_W-1:0] duration;
    logic                    clear;
  } cmd_t;

endpackage

// File: src/dtb_front.sv
// ----------------------------------------------------------------------------
// dtb_front
// Input stage: takes one request, range checks the slot and folds the
// operation into a command for the queue.
// ----------------------------------------------------------------------------
module dtb_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dtb_pkg::KIND_W-1:0]         in_kind,
  input  logic [dtb_pkg::INSLOT_W-1:0]       in_slot,
  input  logic signed [dtb_pkg::DUR_W-1:0]   in_duration,
  input  logic                               in_clear,
  output logic                               push_valid,
  input  logic                               push_ready,
  output dtb_pkg::cmd_t                      push_data
);

  logic          valid_r;
  dtb_pkg::cmd_t cmd_r;
  dtb_pkg::cmd_t cmd_nxt;
  logic          slot_ok;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_data  = cmd_r;

  assign slot_ok = (in_slot < dtb_pkg::INSLOT_W'(dtb_pkg::NUM_SLOTS));

  always_comb begin
    cmd_nxt.kind     = in_kind;
    cmd_nxt.slot_ok  = slot_ok;
    cmd_nxt.slot     = in_slot[dtb_pkg::SLOT_W-1:0];
    cmd_nxt.duration = in_duration;
    cmd_nxt.clear    = in_clear;
    case (in_kind)
      dtb_pkg::KIND_TICK, dtb_pkg::KIND_SET_ALL, dtb_pkg::KIND_QUERY,
      dtb_pkg::KIND_OLDEST: begin
      end
      // out-of-range set or search start has no effect and the default answer
      dtb_pkg::KIND_SET_ONE, dtb_pkg::KIND_EXPIRED: begin
        if (!slot_ok) cmd_nxt.kind = dtb_pkg::KIND_NOP;
      end
      default: cmd_nxt.kind = dtb_pkg::KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (push_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: src/dtb_fifo.sv
// ----------------------------------------------------------------------------
// dtb_fifo
// Short command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module dtb_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dtb_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dtb_pkg::cmd_t pop_data
);

  dtb_pkg::cmd_t                 mem_r [dtb_pkg::QDEPTH];
  logic [dtb_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [dtb_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [dtb_pkg::QCNT_W-1:0]    count_r;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (count_r != dtb_pkg::QCNT_W'(dtb_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == dtb_pkg::QPTR_W'(dtb_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == dtb_pkg::QPTR_W'(dtb_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= dtb_pkg::QCNT_W'(dtb_pkg::QDEPTH))
    else $error("command queue overfilled");

endmodule

// File: src/dtb_back.sv
// ----------------------------------------------------------------------------
// dtb_back
// Execution unit: owns the tick count and slot state, runs one command at a
// time, scans the slots one per cycle for searches and holds the result.
// ----------------------------------------------------------------------------
module dtb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  dtb_pkg::cmd_t                     cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtb_pkg::FOUND_W-1:0]       out_found_slot,
  output logic signed [dtb_pkg::DL_W-1:0]   out_remaining,
  output logic                              out_is_cleared
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int DL_W   = dtb_pkg::DL_W;
  localparam int SLOT_W = dtb_pkg::SLOT_W;

  logic [1:0]                       state_r, state_nxt;
  logic [dtb_pkg::NOW_W-1:0]        now_r;
  logic [dtb_pkg::NUM_SLOTS-1:0]    off_r;
  logic signed [DL_W-1:0]           deadline_r [dtb_pkg::NUM_SLOTS];

  logic [SLOT_W-1:0]                idx_r;
  logic [dtb_pkg::CNT_W-1:0]        cnt_r;
  logic                             oldest_r;
  logic [dtb_pkg::FOUND_W-1:0]      found_r;
  logic signed [DL_W-1:0]           best_r;

  logic                             out_valid_r;
  logic [dtb_pkg::FOUND_W-1:0]      out_found_r;
  logic signed [DL_W-1:0]           out_rem_r;
  logic                             out_clr_r;

  logic                             out_free;
  logic                             pop;
  logic [SLOT_W-1:0]                rd_idx;
  logic signed [DL_W-1:0]           rd_dl;
  logic signed [DL_W-1:0]           now_ext;
  logic signed [DL_W-1:0]           target;
  logic signed [DL_W-1:0]           rem_calc;
  logic                             rd_expired;
  logic                             found_none;
  logic                             load_out;
  logic [dtb_pkg::FOUND_W-1:0]      res_found;
  logic signed [DL_W-1:0]           res_rem;
  logic                             res_clr;

  assign out_free   = !out_valid_r || out_ready;
  assign cmd_ready  = (state_r == ST_IDLE) && out_free;
  assign pop        = cmd_valid && cmd_ready;

  assign rd_idx     = (state_r == ST_SCAN) ? idx_r : cmd.slot;
  assign rd_dl      = deadline_r[rd_idx];
  assign now_ext    = $signed({2'b00, now_r});
  assign target     = now_ext + {{(DL_W - dtb_pkg::DUR_W){cmd.duration[dtb_pkg::DUR_W-1]}},
                                 cmd.duration};
  assign rem_calc   = rd_dl - now_ext;
  assign rd_expired = !off_r[rd_idx] && (rd_dl <= now_ext);
  assign found_none = (found_r == dtb_pkg::SLOT_NONE);

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    res_found = dtb_pkg::SLOT_NONE;
    res_rem   = '0;
    res_clr   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (cmd.kind)
            dtb_pkg::KIND_EXPIRED, dtb_pkg::KIND_OLDEST: state_nxt = ST_SCAN;
            dtb_pkg::KIND_QUERY: begin
              load_out = 1'b1;
              if (!cmd.slot_ok || off_r[cmd.slot]) begin
                res_clr = 1'b1;
              end else begin
                res_rem = rem_calc;
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_r == dtb_pkg::CNT_W'(dtb_pkg::NUM_SLOTS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_found = found_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      now_r       <= '0;
      off_r       <= '1;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        case (cmd.kind)
          dtb_pkg::KIND_TICK: begin
            if (now_r != dtb_pkg::NOW_MAX) now_r <= now_r + 1'b1;
          end
          dtb_pkg::KIND_SET_ONE: off_r[cmd.slot] <= cmd.clear;
          dtb_pkg::KIND_SET_ALL: off_r <= {dtb_pkg::NUM_SLOTS{cmd.clear}};
          default: begin
          end
        endcase
      end
    end
  end

  // Deadline store: written only when a slot is armed.
  always_ff @(posedge clk) begin
    if (pop && !cmd.clear) begin
      case (cmd.kind)
        dtb_pkg::KIND_SET_ONE: deadline_r[cmd.slot] <= target;
        dtb_pkg::KIND_SET_ALL: begin
          for (int i = 0; i < dtb_pkg::NUM_SLOTS; i++) deadline_r[i] <= target;
        end
        default: begin
        end
      endcase
    end
  end

  // Search walker: one slot per cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      idx_r    <= (cmd.kind == dtb_pkg::KIND_EXPIRED) ? cmd.slot : '0;
      oldest_r <= (cmd.kind == dtb_pkg::KIND_OLDEST);
      cnt_r    <= '0;
      found_r  <= dtb_pkg::SLOT_NONE;
    end else if (state_r == ST_SCAN) begin
      idx_r <= (idx_r == SLOT_W'(dtb_pkg::NUM_SLOTS - 1)) ? '0 : idx_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
      if (oldest_r) begin
        if (!off_r[idx_r] && (found_none || rd_dl < best_r)) begin
          found_r <= dtb_pkg::FOUND_W'(idx_r);
          best_r  <= rd_dl;
        end
      end else if (found_none && rd_expired) begin
        found_r <= dtb_pkg::FOUND_W'(idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= res_found;
      out_rem_r   <= res_rem;
      out_clr_r   <= res_clr;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found_slot = out_found_r;
  assign out_remaining  = out_rem_r;
  assign out_is_cleared = out_clr_r;

  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < dtb_pkg::CNT_W'(dtb_pkg::NUM_SLOTS)))
    else $error("slot scan ran past the last slot");

  a_found_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !found_none) |-> !off_r[found_r[SLOT_W-1:0]])
    else $error("search answered a cleared slot");

  a_now_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (now_r >= $past(now_r)))
    else $error("tick count went backward");

  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (state_r == ST_IDLE))
    else $error("result loaded while a command was still running");

endmodule

// File: src/deadline_timer_bank.sv
// ----------------------------------------------------------------------------
// deadline_timer_bank
// Bank of deadline timers on a saturating tick count that tick commands advance.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A request goes through an input
// register, a two-entry command queue and the execution unit; tick, set and
// query commands finish as the execution unit takes them and stream at one
// per cycle when results are taken at once, passing the input register, the
// queue and the result register. The two searches walk the slots one per
// cycle through the execution unit and hold it until the result is loaded;
// meanwhile the queue and input register keep taking up to three more
// requests. Slot deadlines are not reset: all slots come up cleared, and
// a deadline is only read once its slot has been armed.
module deadline_timer_bank (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dtb_pkg::KIND_W-1:0]        in_kind,
  input  logic [dtb_pkg::INSLOT_W-1:0]      in_slot,
  input  logic signed [dtb_pkg::DUR_W-1:0]  in_duration,
  input  logic                              in_clear,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtb_pkg::FOUND_W-1:0]       out_found_slot,
  output logic signed [dtb_pkg::DL_W-1:0]   out_remaining,
  output logic                              out_is_cleared
);

  logic          push_valid;
  logic          push_ready;
  dtb_pkg::cmd_t push_data;
  logic          cmd_valid;
  logic          cmd_ready;
  dtb_pkg::cmd_t cmd;

  dtb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_slot     (in_slot),
    .in_duration (in_duration),
    .in_clear    (in_clear),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  dtb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_data   (cmd)
  );

  dtb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found_slot (out_found_slot),
    .out_remaining  (out_remaining),
    .out_is_cleared (out_is_cleared)
  );

endmodule
